[hdl/battery_gauge_with_tx_current_macros.svh]
// ---------------------------------------------------------------------------
// Battery gauge assertion macros
// Assertion wrappers shared by the RTL; they compile away under synthesis.
// ---------------------------------------------------------------------------
`ifndef BATTERY_GAUGE_WITH_TX_CURRENT_MACROS_SVH
`define BATTERY_GAUGE_WITH_TX_CURRENT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define BG_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// condition must never be true outside reset
`define BG_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define BG_ASSERT(label, clk, rst_n, prop)
`define BG_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

[hdl/bgtx_pkg.sv]
// ---------------------------------------------------------------------------
// bgtx_pkg
// Constants, codes and widths of the battery gauge.
// ---------------------------------------------------------------------------
package bgtx_pkg;

  // widths
  localparam int unsigned RawW   = 12;
  localparam int unsigned LevelW = 11;
  localparam int unsigned DivW   = 26;  // covers 4095 * 10000
  localparam int unsigned QuoW   = 9;   // widest quotient (resistance, up to 275)
  localparam int unsigned CntW   = 4;

  // display style codes
  localparam logic [1:0] StyleBar  = 2'd1;
  localparam logic [1:0] StylePct  = 2'd2;
  localparam logic [1:0] StyleVolt = 2'd3;

  // register index (paddr bit 2)
  localparam logic RegStyle  = 1'b0;
  localparam logic RegEnable = 1'b1;

  // level and display
  localparam logic [RawW-1:0]   LevelOffset = 12'd2828;
  localparam logic [LevelW-1:0] ColorHigh   = 11'd950;
  localparam logic [LevelW-1:0] ColorLow    = 11'd316;
  localparam logic [1:0]        ColorLowC   = 2'd0;
  localparam logic [1:0]        ColorNormC  = 2'd1;
  localparam logic [1:0]        ColorHighC  = 2'd2;
  localparam logic [6:0]        VoltBase    = 7'd58;

  // quotient bits per division
  localparam logic [CntW-1:0] BarQ  = 4'd5;
  localparam logic [CntW-1:0] PctQ  = 4'd7;
  localparam logic [CntW-1:0] VoltQ = 4'd5;
  localparam logic [CntW-1:0] IrQ   = 4'd9;
  localparam logic [CntW-1:0] CurQ  = 4'd8;

  // divisors aligned to the top quotient bit
  localparam logic [DivW-1:0] DsrBar  = 26'd66   << 4;
  localparam logic [DivW-1:0] DsrPct  = 26'd76   << 6;
  localparam logic [DivW-1:0] DsrVolt = 26'd48   << 4;
  localparam logic [DivW-1:0] DsrIr   = 26'd1000 << 8;

  // current estimate
  localparam logic [18:0]     IrIntercept = 19'd275560;
  localparam logic [QuoW-1:0] IrMin       = 9'd30;
  localparam logic [QuoW-1:0] IrMax       = 9'd100;
  localparam logic [DivW-1:0] DiffScale   = 26'd10000;
  localparam logic [15:0]     CurDiv      = 16'd488;
  localparam logic [QuoW-1:0] CurMax      = 9'd99;

endpackage

[hdl/battery_gauge_with_tx_current.sv]
// ---------------------------------------------------------------------------
// battery_gauge_with_tx_current
// Battery level, display values and transmit current estimate from one
// converter sample, computed on a shared shift-subtract divider.
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   --------  ---------  ---------------------  ---------------------------------
//   in        sink       in_valid_i/in_stall_o   adc_high_byte, adc_low_byte, tx
//   out       source     out_valid_o/out_stall_i level .. current_valid
//   config    APB slave  psel/penable/pready     display_style, estimate enable
//
// Sequence: one divider retires one quotient bit per cycle and sets the rate.
//   An item runs the bar, percent and volts divisions, plus the internal
//   resistance division, a multiply step and the current division when an
//   estimate is made, then loads the output register; the input stalls until
//   then, and a new item is taken the cycle after that load.
// Reset: async, active low; clears state, stored readings and config.
// Stalls: a held result sits in the output register; the next item is
//   accepted and computed, and only the final load waits for it to drain.
//
`include "battery_gauge_with_tx_current_macros.svh"

module battery_gauge_with_tx_current
  import bgtx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  adc_high_byte_i,
  input  logic [7:0]  adc_low_byte_i,
  input  logic        transmitting_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] level_o,
  output logic [1:0]  color_class_o,
  output logic [4:0]  bar_length_o,
  output logic [6:0]  percent_o,
  output logic [6:0]  volts_tenths_o,
  output logic [6:0]  shown_value_o,
  output logic [6:0]  current_tenths_o,
  output logic        current_valid_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BAR,
    S_PCT,
    S_VOLT,
    S_IR,
    S_MUL,
    S_CUR,
    S_DONE
  } state_e;

  state_e state_q;

  // config registers
  logic [1:0] style_q;
  logic       est_en_q;

  // stored readings
  logic [RawW-1:0] rx_rd_q, tx_rd_q;
  logic            is_tx_q;

  // per-item results
  logic [LevelW-1:0] level_q;
  logic [4:0]        bar_q;
  logic [6:0]        pct_q, volts_q, cur_q;
  logic              cur_valid_q;
  logic [6:0]        ir_q;

  // divider
  logic [DivW-1:0] rem_q, dsr_q;
  logic [QuoW-1:0] quo_q;
  logic [CntW-1:0] cnt_q;

  // output register
  logic              out_valid_q;
  logic [LevelW-1:0] o_level_q;
  logic [1:0]        o_color_q;
  logic [4:0]        o_bar_q;
  logic [6:0]        o_pct_q, o_volts_q, o_shown_q, o_cur_q;
  logic              o_cur_valid_q;

  // ---------------------------------------------------------------------
  // APB config port: always ready, index in paddr bit 2
  // ---------------------------------------------------------------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      style_q  <= StyleBar;
      est_en_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegStyle:  style_q  <= pwdata[1:0];
        RegEnable: est_en_q <= pwdata[0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegStyle:  prdata = {30'b0, style_q};
      RegEnable: prdata = {31'b0, est_en_q};
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------
  logic              in_acc;
  logic [RawW-1:0]   raw;
  logic [RawW-1:0]   raw_off;
  logic [LevelW-1:0] level_new;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign raw        = {adc_high_byte_i, adc_low_byte_i[7:4]};
  assign raw_off    = raw - LevelOffset;
  assign level_new  = (raw > LevelOffset) ? raw_off[LevelW-1:0] : '0;

  // level * 6 as shifts
  logic [13:0] level_x6;
  assign level_x6 = {1'b0, level_q, 2'b0} + {2'b0, level_q, 1'b0};

  // internal resistance numerator: 275560 - 60 * rx
  logic [18:0] ir_num;
  assign ir_num = IrIntercept - ({1'b0, rx_rd_q, 6'b0} - {5'b0, rx_rd_q, 2'b0});

  // droop; a negative droop clamps to zero current
  logic [RawW:0]   diff;
  logic [DivW-1:0] prod;
  logic [15:0]     den;
  assign diff = {1'b0, rx_rd_q} - {1'b0, tx_rd_q};
  assign prod = DivW'(diff[RawW-1:0]) * DiffScale;
  assign den  = 16'(ir_q) * CurDiv;

  // ---------------------------------------------------------------------
  // shift-subtract step: one quotient bit per cycle
  // ---------------------------------------------------------------------
  logic            div_busy, ge, last;
  logic [DivW-1:0] rem_sub;
  logic [QuoW-1:0] quo_nx;

  assign div_busy = (state_q == S_BAR) || (state_q == S_PCT) || (state_q == S_VOLT) ||
                    (state_q == S_IR) || (state_q == S_CUR);
  assign ge       = (rem_q >= dsr_q);
  assign rem_sub  = rem_q - dsr_q;
  assign quo_nx   = {quo_q[QuoW-2:0], ge};
  assign last     = (cnt_q == CntW'(1));

  logic est_go;
  assign est_go = est_en_q && is_tx_q && ((style_q == StylePct) || (style_q == StyleVolt));

  logic [6:0] ir_clamped, cur_clamped;
  assign ir_clamped  = (quo_nx < IrMin) ? IrMin[6:0] :
                       (quo_nx > IrMax) ? IrMax[6:0] : quo_nx[6:0];
  assign cur_clamped = (quo_nx > CurMax) ? CurMax[6:0] : quo_nx[6:0];

  // final display values
  logic [1:0] color_nx;
  logic [6:0] shown_nx;
  assign color_nx = (level_q > ColorHigh) ? ColorHighC :
                    (level_q < ColorLow)  ? ColorLowC  : ColorNormC;
  always_comb begin
    case (style_q)
      StylePct:  shown_nx = pct_q;
      StyleVolt: shown_nx = volts_q;
      default:   shown_nx = {2'b0, bar_q};
    endcase
  end

  // result moves into the output register when that is empty or draining
  logic out_load;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // ---------------------------------------------------------------------
  // sequencer, datapath and output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rx_rd_q     <= '0;
      tx_rd_q     <= '0;
      cnt_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // on the last bit the state below reloads or leaves the divider
      if (div_busy && !last) begin
        rem_q <= ge ? rem_sub : rem_q;
        dsr_q <= dsr_q >> 1;
        quo_q <= quo_nx;
        cnt_q <= cnt_q - CntW'(1);
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (transmitting_i) begin
              tx_rd_q <= raw;
            end else begin
              rx_rd_q <= raw;
            end
            is_tx_q <= transmitting_i;
            level_q <= level_new;
            rem_q   <= DivW'(level_new);
            dsr_q   <= DsrBar;
            quo_q   <= '0;
            cnt_q   <= BarQ;
            state_q <= S_BAR;
          end
        end
        S_BAR: begin
          if (last) begin
            bar_q   <= quo_nx[4:0];
            rem_q   <= DivW'(level_x6);
            dsr_q   <= DsrPct;
            quo_q   <= '0;
            cnt_q   <= PctQ;
            state_q <= S_PCT;
          end
        end
        S_PCT: begin
          if (last) begin
            pct_q   <= quo_nx[6:0];
            rem_q   <= DivW'(level_q);
            dsr_q   <= DsrVolt;
            quo_q   <= '0;
            cnt_q   <= VoltQ;
            state_q <= S_VOLT;
          end
        end
        S_VOLT: begin
          if (last) begin
            volts_q <= {2'b0, quo_nx[4:0]} + VoltBase;
            if (est_go) begin
              rem_q   <= DivW'(ir_num);
              dsr_q   <= DsrIr;
              quo_q   <= '0;
              cnt_q   <= IrQ;
              state_q <= S_IR;
            end else begin
              cur_q       <= '0;
              cur_valid_q <= 1'b0;
              state_q     <= S_DONE;
            end
          end
        end
        S_IR: begin
          if (last) begin
            ir_q    <= ir_clamped;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          // (d * 10000 / ir) / 488 equals d * 10000 / (ir * 488)
          rem_q   <= diff[RawW] ? '0 : prod;
          dsr_q   <= {3'b0, den, 7'b0};
          quo_q   <= '0;
          cnt_q   <= CurQ;
          state_q <= S_CUR;
        end
        S_CUR: begin
          if (last) begin
            cur_q       <= cur_clamped;
            cur_valid_q <= 1'b1;
            state_q     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            o_level_q     <= level_q;
            o_color_q     <= color_nx;
            o_bar_q       <= bar_q;
            o_pct_q       <= pct_q;
            o_volts_q     <= volts_q;
            o_shown_q     <= shown_nx;
            o_cur_q       <= cur_q;
            o_cur_valid_q <= cur_valid_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign level_o          = o_level_q;
  assign color_class_o    = o_color_q;
  assign bar_length_o     = o_bar_q;
  assign percent_o        = o_pct_q;
  assign volts_tenths_o   = o_volts_q;
  assign shown_value_o    = o_shown_q;
  assign current_tenths_o = o_cur_q;
  assign current_valid_o  = o_cur_valid_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `BG_ASSERT(a_accept_starts_bar, clk_i, rst_ni, in_acc |=> (state_q == S_BAR))
  `BG_ASSERT_NEVER(a_div_cnt_empty, clk_i, rst_ni, div_busy && (cnt_q == '0))
  `BG_ASSERT(a_cur_range, clk_i, rst_ni, out_valid_q |-> (o_cur_q <= CurMax[6:0]))
  `BG_ASSERT(a_cur_zero, clk_i, rst_ni, (out_valid_q && !o_cur_valid_q) |-> (o_cur_q == '0))

endmodule

[verif/testbench.sv]
// ---------------------------------------------------------------------------
// Battery gauge testbench
// Sends converter samples through the valid/stall input channel, with random
// gaps and output stalls, and checks every result item field by field
// against an in-bench model of the gauge and the transmit current estimate,
// or a result typed by hand. A short directed list of samples comes first,
// then random receive/transmit pairs under a series of register settings.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bgtx_pkg::*;

  // -------------------------------------------------------------------------
  // Constants of the gauge arithmetic
  // -------------------------------------------------------------------------
  localparam int BarDiv   = 66;
  localparam int PctMul   = 6;
  localparam int PctDiv   = 76;
  localparam int VoltDiv  = 48;
  localparam int IrSlope  = 60;
  localparam int IrScale  = 1000;
  localparam int DroopMul = 10000;
  localparam int AmpDiv   = 488;

  // style 0 is legal in the register and falls back to the icon bar
  localparam logic [1:0] StyleZero = 2'd0;

  // register byte addresses: index 0 at 0, index 1 at 4
  localparam logic [2:0] AddrStyle  = {RegStyle, 2'b00};
  localparam logic [2:0] AddrEnable = {RegEnable, 2'b00};

  localparam int RandomItems = 1250;

  // -------------------------------------------------------------------------
  // Types
  // -------------------------------------------------------------------------
  typedef struct packed {
    logic [10:0] level;
    logic [1:0]  color;
    logic [4:0]  bar;
    logic [6:0]  pct;
    logic [6:0]  volts;
    logic [6:0]  shown;
    logic [6:0]  cur;
    logic        cur_valid;
  } gauge_result_t;

  // one directed sample; the register setting it runs under and, where the
  // result is obvious, the result typed in by hand
  typedef struct packed {
    logic [1:0]    style;
    logic          en;
    logic [7:0]    hi;
    logic [7:0]    lo;
    logic          tx;
    logic          typed;
    gauge_result_t want;
  } stim_row_t;

  // -------------------------------------------------------------------------
  // DUT signals
  // -------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  adc_high_byte_i;
  logic [7:0]  adc_low_byte_i;
  logic        transmitting_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [10:0] level_o;
  logic [1:0]  color_class_o;
  logic [4:0]  bar_length_o;
  logic [6:0]  percent_o;
  logic [6:0]  volts_tenths_o;
  logic [6:0]  shown_value_o;
  logic [6:0]  current_tenths_o;
  logic        current_valid_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  battery_gauge_with_tx_current dut (.*);

  always #10 clk_i = ~clk_i;

  // -------------------------------------------------------------------------
  // Gauge model state: register copies and the stored readings
  // -------------------------------------------------------------------------
  logic [1:0]    style_q;
  logic          en_q;
  logic [11:0]   rx_reading;
  logic [11:0]   tx_reading;

  gauge_result_t pending_readings[$];  // results still owed by the DUT
  gauge_result_t oldest_reading;

  int mismatches      = 0;
  int samples_sent    = 0;
  int results_checked = 0;
  int estimates_seen  = 0;
  int reg_writes      = 0;
  bit tx_quiet        = 1'b0;  // sender runs back to back when set
  bit rx_calm         = 1'b0;  // receiver never stalls when set
  int calm_left       = 0;
  int stall_left      = 0;

  // -------------------------------------------------------------------------
  // Directed samples: extremes, thresholds, every style, estimate corners
  // -------------------------------------------------------------------------
  localparam int NumRows = 22;
  stim_row_t stim_rows [NumRows] = '{
    // reset settings, all-zero sample
    '{StyleBar, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1,
      '{11'd0, ColorLowC, 5'd0, 7'd0, VoltBase, 7'd0, 7'd0, 1'b0}},
    // full scale
    '{StyleBar, 1'b0, 8'hFF, 8'hFF, 1'b0, 1'b1,
      '{11'd1267, ColorHighC, 5'd19, 7'd100, 7'd84, 7'd19, 7'd0, 1'b0}},
    // low nibble of the low byte must be ignored
    '{StyleBar, 1'b0, 8'hB0, 8'h0F, 1'b0, 1'b1,
      '{11'd0, ColorLowC, 5'd0, 7'd0, VoltBase, 7'd0, 7'd0, 1'b0}},
    // exactly at the offset, then one above
    '{StyleBar, 1'b0, 8'hB0, 8'hC0, 1'b0, 1'b1,
      '{11'd0, ColorLowC, 5'd0, 7'd0, VoltBase, 7'd0, 7'd0, 1'b0}},
    '{StyleBar, 1'b0, 8'hB0, 8'hD0, 1'b0, 1'b1,
      '{11'd1, ColorLowC, 5'd0, 7'd0, VoltBase, 7'd0, 7'd0, 1'b0}},
    // color boundaries at 315/316 and 950/951
    '{StyleBar, 1'b0, 8'hC4, 8'h70, 1'b0, 1'b0, '0},
    '{StyleBar, 1'b0, 8'hC4, 8'h80, 1'b0, 1'b0, '0},
    '{StyleBar, 1'b0, 8'hEC, 8'h20, 1'b0, 1'b0, '0},
    '{StyleBar, 1'b0, 8'hEC, 8'h30, 1'b1, 1'b0, '0},
    // estimate with the current clamped high
    '{StylePct, 1'b1, 8'h00, 8'h00, 1'b1, 1'b1,
      '{11'd0, ColorLowC, 5'd0, 7'd0, VoltBase, 7'd0, 7'd99, 1'b1}},
    // transmit above receive: negative droop floors at zero
    '{StylePct, 1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1,
      '{11'd1267, ColorHighC, 5'd19, 7'd100, 7'd84, 7'd100, 7'd0, 1'b1}},
    // receive sample never estimates
    '{StylePct, 1'b1, 8'hFF, 8'hFF, 1'b0, 1'b1,
      '{11'd1267, ColorHighC, 5'd19, 7'd100, 7'd84, 7'd100, 7'd0, 1'b0}},
    // full droop with the resistance clamped low
    '{StylePct, 1'b1, 8'h00, 8'h00, 1'b1, 1'b1,
      '{11'd0, ColorLowC, 5'd0, 7'd0, VoltBase, 7'd0, 7'd99, 1'b1}},
    // realistic droop in voltage style
    '{StyleVolt, 1'b1, 8'hE1, 8'h00, 1'b0, 1'b0, '0},
    '{StyleVolt, 1'b1, 8'hDA, 8'hC0, 1'b1, 1'b0, '0},
    '{StyleVolt, 1'b1, 8'hE1, 8'h0F, 1'b1, 1'b0, '0},
    // style zero and icon style never estimate; nor does enable off
    '{StyleZero, 1'b1, 8'hDA, 8'hC0, 1'b1, 1'b0, '0},
    '{StyleBar,  1'b1, 8'hDA, 8'hC0, 1'b1, 1'b0, '0},
    '{StyleVolt, 1'b0, 8'hDA, 8'hC0, 1'b1, 1'b0, '0},
    // alternating bit patterns
    '{StyleVolt, 1'b1, 8'h55, 8'hAA, 1'b1, 1'b0, '0},
    '{StyleVolt, 1'b1, 8'hAA, 8'h55, 1'b0, 1'b0, '0},
    '{StylePct,  1'b1, 8'h80, 8'h00, 1'b1, 1'b0, '0}
  };

  // -------------------------------------------------------------------------
  // Gauge model: stores the reading and returns the result it causes
  // -------------------------------------------------------------------------
  function automatic gauge_result_t predict_gauge(input logic [7:0] hi,
                                                  input logic [7:0] lo,
                                                  input logic tx);
    logic [11:0]   raw;
    int            lvl;
    int            r_ohm;
    int            amps;
    gauge_result_t r;
    raw = {hi, lo[7:4]};
    if (tx) tx_reading = raw;
    else    rx_reading = raw;

    lvl = int'(raw) - int'(LevelOffset);
    if (lvl < 0) lvl = 0;
    r.level = lvl[10:0];
    if (lvl > int'(ColorHigh))     r.color = ColorHighC;
    else if (lvl < int'(ColorLow)) r.color = ColorLowC;
    else                           r.color = ColorNormC;
    r.bar   = 5'(lvl / BarDiv);
    r.pct   = 7'(lvl * PctMul / PctDiv);
    r.volts = 7'(lvl / VoltDiv + int'(VoltBase));
    case (style_q)
      StylePct:  r.shown = r.pct;
      StyleVolt: r.shown = r.volts;
      default:   r.shown = 7'(r.bar);
    endcase

    r.cur       = '0;
    r.cur_valid = 1'b0;
    if ((style_q == StylePct || style_q == StyleVolt) && en_q && tx) begin
      // internal resistance in milliohms from the resting voltage
      r_ohm = (int'(IrIntercept) - IrSlope * int'(rx_reading)) / IrScale;
      if (r_ohm < int'(IrMin)) r_ohm = int'(IrMin);
      if (r_ohm > int'(IrMax)) r_ohm = int'(IrMax);
      // int division truncates toward zero, as the hardware must
      amps = (int'(rx_reading) - int'(tx_reading)) * DroopMul / r_ohm / AmpDiv;
      if (amps < 0) amps = 0;
      if (amps > int'(CurMax)) amps = int'(CurMax);
      r.cur       = 7'(amps);
      r.cur_valid = 1'b1;
    end
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_cycles();
    if ($urandom_range(9) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  // -------------------------------------------------------------------------
  // Input channel driver. Entered and left right after a falling edge; valid
  // stays high on return so back-to-back items never drop it.
  // -------------------------------------------------------------------------
  task automatic push_sample(input logic [7:0] hi, input logic [7:0] lo,
                             input logic tx, input logic typed,
                             input gauge_result_t want);
    int            gap;
    gauge_result_t guess;
    gap = (tx_quiet || $urandom_range(2) != 0) ? 0 : gap_cycles();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    adc_high_byte_i <= hi;
    adc_low_byte_i  <= lo;
    transmitting_i  <= tx;
    do @(posedge clk_i); while (in_stall_o);
    guess = predict_gauge(hi, lo, tx);
    pending_readings.push_back(typed ? want : guess);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // APB write followed by a read back of the same register
  task automatic set_register(input logic [2:0] addr, input logic [31:0] value,
                              input logic [31:0] mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== (value & mask)) begin
      $error("register %0d: expected %0h, got %0h", addr, value & mask, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
  endtask

  // Registers change only with the block idle: stop sending, let every
  // owed result drain, then write both registers (junk in the upper bits).
  task automatic apply_config(input logic [1:0] style, input logic en);
    logic [31:0] word;
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
    word      = $urandom;
    word[1:0] = style;
    set_register(AddrStyle, word, 32'h3);
    style_q   = style;
    word      = $urandom;
    word[0]   = en;
    set_register(AddrEnable, word, 32'h1);
    en_q      = en;
  endtask

  task automatic check_field(input string name, input logic [10:0] want,
                             input logic [10:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // -------------------------------------------------------------------------
  // Output stall: calm stretches with no stall, busy stretches with random
  // stalls of mostly short length
  // -------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (calm_left == 0) begin
      calm_left = $urandom_range(40, 300);
      rx_calm   = ($urandom_range(3) == 0);
    end
    calm_left--;
    if (stall_left == 0 && !rx_calm && $urandom_range(3) == 0)
      stall_left = gap_cycles();
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // -------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        $error("result item with nothing expected (level %0d)", level_o);
        mismatches++;
      end else begin
        oldest_reading = pending_readings.pop_front();
        check_field("level",          oldest_reading.level,          level_o);
        check_field("color_class",    11'(oldest_reading.color),     11'(color_class_o));
        check_field("bar_length",     11'(oldest_reading.bar),       11'(bar_length_o));
        check_field("percent",        11'(oldest_reading.pct),       11'(percent_o));
        check_field("volts_tenths",   11'(oldest_reading.volts),     11'(volts_tenths_o));
        check_field("shown_value",    11'(oldest_reading.shown),     11'(shown_value_o));
        check_field("current_tenths", 11'(oldest_reading.cur),       11'(current_tenths_o));
        check_field("current_valid",  11'(oldest_reading.cur_valid), 11'(current_valid_o));
        results_checked++;
        if (oldest_reading.cur_valid) estimates_seen++;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    int          phase;
    int          rx_raw;
    int          tx_raw;
    int          droop;
    int          guard;
    logic [1:0]  sty;
    logic [1:0]  style_cycle [4];
    logic [11:0] raw;

    style_cycle = '{StyleBar, StyleVolt, StylePct, StyleZero};

    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    adc_high_byte_i = '0;
    adc_low_byte_i  = '0;
    transmitting_i  = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    style_q         = StyleBar;
    en_q            = 1'b0;
    rx_reading      = '0;
    tx_reading      = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed list; reconfigure whenever a row asks for other settings
    foreach (stim_rows[i]) begin
      if (stim_rows[i].style != style_q || stim_rows[i].en != en_q)
        apply_config(stim_rows[i].style, stim_rows[i].en);
      push_sample(stim_rows[i].hi, stim_rows[i].lo, stim_rows[i].tx,
                  stim_rows[i].typed, stim_rows[i].want);
    end

    // random phases, each under its own settings; the first four walk all
    // styles with the estimate enable alternating on and off, later ones are random
    phase = 0;
    while (samples_sent < NumRows + RandomItems) begin
      sty = (phase < 4) ? style_cycle[phase] : 2'($urandom_range(3));
      apply_config(sty, (phase < 4) ? logic'(phase % 2 == 0) : logic'($urandom_range(1)));
      tx_quiet = (phase % 3 == 2);
      repeat (60) begin
        if ($urandom_range(9) < 7) begin
          // receive reading then a transmit reading near it, mostly below
          rx_raw = $urandom_range(2700, 4095);
          droop  = $urandom_range(0, 420) - 20;
          tx_raw = rx_raw - droop;
          if (tx_raw < 0)    tx_raw = 0;
          if (tx_raw > 4095) tx_raw = 4095;
          raw = 12'(rx_raw);
          push_sample(raw[11:4], {raw[3:0], 4'($urandom)}, 1'b0, 1'b0, '0);
          raw = 12'(tx_raw);
          push_sample(raw[11:4], {raw[3:0], 4'($urandom)}, 1'b1, 1'b0, '0);
        end else begin
          // noise: any byte values, either direction
          push_sample(8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
        end
      end
      phase++;
    end

    // final drain, bounded
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_readings.size() != 0 && guard < 5000) begin
      @(negedge clk_i);
      guard++;
    end
    if (pending_readings.size() != 0) begin
      $error("%0d result items never arrived", pending_readings.size());
      mismatches++;
    end
    repeat (40) @(negedge clk_i);

    $display("sent %0d samples, %0d random phases (%0d register writes)",
             samples_sent, phase, reg_writes);
    $display("checked %0d result items, %0d carrying a current estimate",
             results_checked, estimates_seen);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #30_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
